// File: src/bfq_pkg.sv
// ----------------------------------------------------------------------------
// bfq_pkg
// Types and constants shared by the block floating-point quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package bfq_pkg;
    typedef struct packed {
        logic [31:0] value_in;
        logic        block_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value_out;
        logic        last_out;
    } t_out_item;

    localparam logic [3:0] REG_TOTAL_BITS    = 4'd0;
    localparam logic [3:0] REG_EXPONENT_BITS = 4'd4;

    localparam logic [5:0] TOTAL_BITS_RESET    = 6'd8;
    localparam logic [3:0] EXPONENT_BITS_RESET = 4'd4;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic store_full;
    } t_status;

    // saturated exponent width, 2..8
    function automatic logic [3:0] exp_width(input logic [3:0] eb);
        logic [3:0] e;
        begin
            e = eb;
            if (e < 4'd2) e = 4'd2;
            if (e > 4'd8) e = 4'd8;
            return e;
        end
    endfunction

    // saturated mantissa bit count, 0..23
    function automatic logic [4:0] mant_bits(input logic [5:0] tb, input logic [3:0] eb);
        logic [6:0] t;
        logic [6:0] d;
        begin
            t = {1'b0, tb};
            d = 7'd1 + {3'd0, exp_width(eb)};
            if (t <= d) return 5'd0;
            if (t - d > 7'd23) return 5'd23;
            return 5'(t - d);
        end
    endfunction
endpackage
`default_nettype wire

// File: src/bfq_ram.sv
// ----------------------------------------------------------------------------
// bfq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/bfq_ctrl.sv
// ----------------------------------------------------------------------------
// bfq_ctrl
// Controller: load phase, then read-out sweep over the stored elements.
// ----------------------------------------------------------------------------
`default_nettype none
module bfq_ctrl #(
    parameter int BLOCK_SIZE = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_block_end,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output bfq_pkg::t_cmd                         o_cmd,
    input  wire bfq_pkg::t_status                 i_status,
    output logic [$clog2(BLOCK_SIZE+1)-1:0]       o_rd_idx,
    output logic                                  o_rd_last
);
    import bfq_pkg::*;

    localparam int CW = $clog2(BLOCK_SIZE + 1);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_READ  = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_valid, n_valid;
    logic          w_acc;
    logic          w_take;

    assign w_acc  = (r_state == S_LOAD) && i_in_valid;
    assign w_take = r_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        o_cmd   = '0;
        if (w_take) n_valid = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (i_block_end || i_status.store_full) begin
                        n_state = S_READ;
                        n_idx   = '0;
                    end
                end
            end
            S_READ: begin
                if (!r_valid || w_take) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.out_load = 1'b1;
                n_valid = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_cnt) begin
                    n_state = S_LOAD;
                    n_cnt   = '0;
                    o_cmd.clear = 1'b1;
                end else begin
                    n_state = S_READ;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_valid;
    assign o_rd_idx    = (r_state == S_LOAD) ? r_cnt : r_idx;
    assign o_rd_last   = (r_idx + 1'b1 == r_cnt);
endmodule
`default_nettype wire

// File: src/bfq_dp.sv
// ----------------------------------------------------------------------------
// bfq_dp
// Datapath: range limiting, shared exponent tracking, element store and
// half-to-even requantization to the shared exponent.
// ----------------------------------------------------------------------------
`default_nettype none
module bfq_dp #(
    parameter int BLOCK_SIZE = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [5:0]                   i_total_bits,
    input  wire logic [3:0]                   i_exponent_bits,
    input  wire bfq_pkg::t_in_item            i_item,
    input  wire bfq_pkg::t_cmd                i_cmd,
    output bfq_pkg::t_status                  o_status,
    input  wire logic [$clog2(BLOCK_SIZE+1)-1:0] i_idx,
    input  wire logic                         i_last,
    output bfq_pkg::t_out_item                o_item
);
    import bfq_pkg::*;

    localparam int AW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int CW = $clog2(BLOCK_SIZE + 1);

    logic [3:0]  w_e;
    logic [4:0]  w_n;
    logic [7:0]  w_max_ef;
    logic [7:0]  w_min_ef;
    logic [22:0] w_max_frac;
    logic [30:0] w_max_mag;
    logic [30:0] w_mag_in;
    logic [30:0] w_lim;
    logic [7:0]  w_ef;
    logic [31:0] w_rdata;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]  r_max_ef;
    logic        r_have;
    logic        r_last;

    // Exponent stored as biased field; 0 stands for the zero exponent -1.
    assign w_e        = exp_width(i_exponent_bits);
    assign w_n        = mant_bits(i_total_bits, i_exponent_bits);
    assign w_max_ef   = 8'd127 + ((8'd1 << (w_e - 4'd1)) - 8'd1);
    assign w_min_ef   = 8'd129 - (8'd1 << (w_e - 4'd1));
    assign w_max_frac = ~(23'h7FFFFF >> w_n);
    assign w_max_mag  = {w_max_ef, w_max_frac};
    assign w_mag_in   = i_item.value_in[30:0];
    assign w_ef       = w_mag_in[30:23];

    always_comb begin
        priority if (w_ef == 8'hFF) w_lim = w_max_mag;
        else if (w_ef == 8'h00) w_lim = '0;
        else if (w_ef < w_min_ef) w_lim = '0;
        else if (w_ef > w_max_ef) w_lim = w_max_mag;
        else if (w_ef == w_max_ef && w_mag_in[22:0] > w_max_frac) w_lim = w_max_mag;
        else w_lim = w_mag_in;
    end

    assign o_status.store_full = (i_idx == CW'(BLOCK_SIZE - 1));
    assign w_waddr = AW'(i_idx);
    assign w_raddr = AW'(i_idx);

    bfq_ram #(.WIDTH(32), .DEPTH(BLOCK_SIZE)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (w_waddr),
        .i_wdata ({i_item.value_in[31], w_lim}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Zero exponent (-1) maps to biased 126 for comparison purposes.
    logic [7:0] w_cmp_new;
    assign w_cmp_new = (w_lim[30:23] == 8'd0) ? 8'd126 : w_lim[30:23];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ef <= 8'd126;
            r_have   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_max_ef <= 8'd126;
            r_have   <= 1'b0;
        end else if (i_cmd.load) begin
            r_have <= 1'b1;
            if (!r_have || w_cmp_new > r_max_ef) r_max_ef <= w_cmp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) r_last <= i_last;
    end

    // Requantize the element read from the store.
    logic [23:0] w_sig;
    logic [7:0]  w_d;
    logic [5:0]  w_s;
    logic [24:0] w_q;
    logic [23:0] w_rem_mask;
    logic [23:0] w_rem;
    logic [23:0] w_half;
    logic [4:0]  w_p;
    logic [9:0]  w_ev;
    logic [31:0] w_res;
    logic [47:0] w_qs;
    logic [8:0]  w_sh;

    always_comb begin
        w_sig = {1'b1, w_rdata[22:0]};
        w_d   = r_max_ef - w_rdata[30:23];
        w_s   = (w_d > 8'd25) ? 6'd63 : 6'(8'd23 + w_d - {3'd0, w_n});
        w_q   = '0;
        w_rem_mask = '0;
        w_rem = '0;
        w_half = '0;
        // a shift of 25 or more leaves less than half an LSB: drop to zero
        if (w_s >= 6'd25) begin
            w_q = '0;
        end else if (w_s == 6'd0) begin
            w_q = {1'b0, w_sig};
        end else begin
            w_rem_mask = ~(24'hFFFFFF << w_s);
            w_rem  = w_sig & w_rem_mask;
            w_half = 24'd1 << (w_s - 6'd1);
            w_q    = {1'b0, w_sig >> w_s};
            if (w_rem > w_half || (w_rem == w_half && w_q[0])) w_q = w_q + 25'd1;
        end
        w_p = '0;
        for (int i = 1; i < 25; i++) begin
            if (w_q[i]) w_p = 5'(i);
        end
        // biased result exponent = max_ef - n + p
        w_ev  = {2'b0, r_max_ef} - {5'd0, w_n} + {5'd0, w_p};
        w_qs  = '0;
        w_sh  = '0;
        w_res = {w_rdata[31], 31'd0};
        if (w_rdata[30:23] != 8'd0 && w_q != '0) begin
            if ($signed(w_ev) > 10'sd254) begin
                w_res = {w_rdata[31], 31'h7F7FFFFF};
            end else if ($signed(w_ev) >= 10'sd1) begin
                w_qs  = {23'd0, w_q} << (5'd23 - w_p);
                w_res = {w_rdata[31], w_ev[7:0], w_qs[22:0]};
            end else begin
                // subnormal: q << (max_ef-127 - n + 149)
                w_sh  = 9'({1'b0, r_max_ef} + 9'd22 - {4'd0, w_n});
                w_qs  = {23'd0, w_q} << w_sh;
                w_res = {w_rdata[31], w_qs[30:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_item.value_out <= w_res;
            o_item.last_out  <= r_last;
        end
    end
endmodule
`default_nettype wire

// File: src/block_float_quantizer_core.sv
// ----------------------------------------------------------------------------
// block_float_quantizer_core
// Block floating-point quantizer with APB-style configuration.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle into a store until block_end or a full
// store; the block then emits every element in turn with a store read
// (S_READ), then a requantize into the output register (S_EMIT),
// quantized to the block's largest exponent. Input stalls during the
// read-out sweep.
`default_nettype none
module block_float_quantizer_core #(
    parameter int BLOCK_SIZE = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire bfq_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bfq_pkg::t_out_item       o_out_data
);
    import bfq_pkg::*;

    localparam int CW = $clog2(BLOCK_SIZE + 1);

    logic [5:0]    r_total_bits;
    logic [3:0]    r_exponent_bits;
    t_cmd          w_cmd;
    t_status       w_status;
    logic [CW-1:0] w_idx;
    logic          w_last;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bits    <= TOTAL_BITS_RESET;
            r_exponent_bits <= EXPONENT_BITS_RESET;
        end else if (psel && penable && pwrite) begin
            if ({1'b0, paddr} == REG_TOTAL_BITS) r_total_bits <= pwdata[5:0];
            if ({1'b0, paddr} == REG_EXPONENT_BITS) r_exponent_bits <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if ({1'b0, paddr} == REG_TOTAL_BITS) prdata = {26'd0, r_total_bits};
        if ({1'b0, paddr} == REG_EXPONENT_BITS) prdata = {28'd0, r_exponent_bits};
    end

    bfq_ctrl #(.BLOCK_SIZE(BLOCK_SIZE)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_block_end (i_in_data.block_end),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status),
        .o_rd_idx    (w_idx),
        .o_rd_last   (w_last)
    );

    bfq_dp #(.BLOCK_SIZE(BLOCK_SIZE)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_total_bits    (r_total_bits),
        .i_exponent_bits (r_exponent_bits),
        .i_item          (i_in_data),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_idx           (w_idx),
        .i_last          (w_last),
        .o_item          (o_out_data)
    );
endmodule
`default_nettype wire

// File: verif/block_float_quantizer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_float_quantizer_core_test
// Self-checking test of the block floating-point quantizer. Directed corner
// values and random blocks go in under several format settings and idle
// patterns, and every output transfer is compared with a predicted value.
// ----------------------------------------------------------------------------
`default_nettype none
module block_float_quantizer_core_test;
    import bfq_pkg::*;

    class bfq_scoreboard;
        logic [5:0]  total_bits;
        logic [3:0]  exp_bits;
        logic [31:0] held[32];
        int          count;
        int          max_exp;
        t_out_item   quant_q[$];
        int          errors;

        function new();
            total_bits = TOTAL_BITS_RESET;
            exp_bits   = EXPONENT_BITS_RESET;
            count      = 0;
            max_exp    = -1;
            errors     = 0;
        endfunction

        function int ewidth();
            int e;
            e = int'(exp_bits);
            if (e < 2) e = 2;
            if (e > 8) e = 8;
            return e;
        endfunction

        function int nmant();
            int n;
            n = int'(total_bits) - 1 - ewidth();
            if (n < 0) n = 0;
            if (n > 23) n = 23;
            return n;
        endfunction

        function int exp_of(logic [31:0] mag);
            if (mag[30:23] == 8'd0) return -1;
            return int'(mag[30:23]) - 127;
        endfunction

        function logic [31:0] limit_mag(logic [31:0] mag);
            int          e, n, min_e, max_e, ex;
            logic [31:0] max_frac, max_mag;
            e        = ewidth();
            n        = nmant();
            min_e    = 2 - (1 << (e - 1));
            max_e    = (1 << (e - 1)) - 1;
            max_frac = (((32'd1 << n) - 32'd1) << (23 - n)) & 32'h007F_FFFF;
            max_mag  = (32'(max_e + 127) << 23) | max_frac;
            if (mag[30:23] == 8'hFF) return max_mag;
            if (mag[30:23] == 8'h00) return 32'd0;
            ex = int'(mag[30:23]) - 127;
            if (ex < min_e) return 32'd0;
            if (ex > max_e) return max_mag;
            if (ex == max_e && {9'd0, mag[22:0]} > max_frac) return max_mag;
            return mag;
        endfunction

        function logic [31:0] quantize(logic [31:0] v, int shared);
            logic [31:0] sgn, mag, frac;
            logic [63:0] sig, q, rem, half;
            int          n, d, s, p, ev;
            sgn = {v[31], 31'd0};
            mag = {1'b0, v[30:0]};
            n   = nmant();
            if (mag[30:23] == 8'd0) return sgn;
            sig = {40'd0, 1'b1, mag[22:0]};
            d   = shared - exp_of(mag);
            if (d < 0) d = 0;
            s = 23 + d - n;
            if (s >= 26) begin
                q = 64'd0;
            end else if (s == 0) begin
                q = sig;
            end else begin
                rem  = sig & ((64'd1 << s) - 64'd1);
                half = 64'd1 << (s - 1);
                q    = sig >> s;
                if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            end
            if (q == 64'd0) return sgn;
            p = 0;
            while (p < 40 && (q >> (p + 1)) != 64'd0) p++;
            ev = shared - n + p;
            if (ev > 127) return sgn | 32'h7F7F_FFFF;
            if (ev >= -126) begin
                frac = 32'((q << (23 - p)) & 64'h7F_FFFF);
                return sgn | (32'(ev + 127) << 23) | frac;
            end
            return sgn | 32'(q << (shared - n + 149));
        endfunction

        function void note_input(t_in_item it);
            logic [31:0] mag;
            t_out_item   res;
            int          ex;
            mag = limit_mag({1'b0, it.value_in[30:0]});
            ex  = exp_of(mag);
            held[count] = {it.value_in[31], mag[30:0]};
            if (count == 0 || ex > max_exp) max_exp = ex;
            count++;
            if (!it.block_end && count < 32) return;
            for (int i = 0; i < count; i++) begin
                res.value_out = quantize(held[i], max_exp);
                res.last_out  = (i + 1 == count);
                quant_q.push_back(res);
            end
            count   = 0;
            max_exp = -1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (quant_q.size() == 0) begin
                $display("%0t: unexpected result value=%h last=%b",
                         $time, got.value_out, got.last_out);
                errors++;
                return;
            end
            want = quant_q.pop_front();
            if (got.value_out !== want.value_out) begin
                $display("%0t: value_out expected %h actual %h",
                         $time, want.value_out, got.value_out);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $display("%0t: last_out expected %b actual %b",
                         $time, want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;

    bfq_scoreboard sb;
    int send_pct;
    int recv_pct;
    int out_count;
    int hold_left;
    bit hold_done;
    int quiet_cycles;

    block_float_quantizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // hold off the output once for a long stretch, else stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (!hold_done && out_count >= 20) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_data);
            out_count = out_count + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] value, input logic last);
        t_in_item it;
        it.value_in  = value;
        it.block_end = last;
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.quant_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(REG_TOTAL_BITS)) sb.total_bits = data[5:0];
        else if (addr == 3'(REG_EXPONENT_BITS)) sb.exp_bits = data[3:0];
    endtask

    task automatic set_format(input logic [5:0] tb, input logic [3:0] eb);
        drain();
        write_reg(3'(REG_TOTAL_BITS), {26'd0, tb});
        write_reg(3'(REG_EXPONENT_BITS), {28'd0, eb});
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0: v[30:0] = 31'd0;
            1: v[30:23] = 8'h00;
            2: v[30:23] = 8'hFF;
            3: ;
            default: v[30:23] = 8'(127 + $urandom_range(0, 40) - 20);
        endcase
        return v;
    endfunction

    task automatic send_blocks(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 11);
            if (r == 0) len = 32;
            else if (r == 1) len = 37;
            else len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_item(rand_value(), (i == len - 1) ? 1'b1 : 1'b0);
            sent += len;
        end
    endtask

    logic [31:0] corner[16] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0080_0000,
        32'h3C00_0000, 32'h3C80_0000, 32'h4170_0000, 32'h4178_0000,
        32'h4380_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
        32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h3F88_0000, 32'hBF98_0000
    };
    logic [5:0] tb_list[9] = '{6'd3, 6'd32, 6'd63, 6'd5, 6'd32, 6'd16, 6'd20, 6'd10, 6'd0};
    logic [3:0] eb_list[9] = '{4'd2, 4'd8, 4'd15, 4'd0, 4'd2, 4'd8, 4'd3, 4'd5, 4'd0};

    initial begin
        sb           = new();
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        send_pct     = 28;
        recv_pct     = 85;
        out_count    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 16; i++)
            send_item(corner[i], (i == 5 || i == 12 || i == 15) ? 1'b1 : 1'b0);

        for (int seg = 0; seg < 9; seg++) begin
            if (seg == 3) begin
                send_pct = 85;
                recv_pct = 28;
            end else if (seg == 6) begin
                send_pct = 0;
                recv_pct = 0;
            end
            if (seg == 8) set_format(6'($urandom()), 4'($urandom()));
            else set_format(tb_list[seg], eb_list[seg]);
            send_blocks(13);
        end

        i_in_valid <= 1'b0;
        while (sb.quant_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.quant_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
src/bfq_pkg.sv
src/bfq_ram.sv
src/bfq_ctrl.sv
src/bfq_dp.sv
src/block_float_quantizer_core.sv
verif/block_float_quantizer_core_test.sv
